/* hw/rtl/rpj_pkg.sv */
// ----------------------------------------------------------------------------
// rpj_pkg
// Shared constants and types for the radar polar Jacobian datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rpj_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // floor register for px^2 + py^2
    localparam int                CFG_W         = 32;
    localparam logic [CFG_W-1:0] MIN_RSQ_RESET = 32'd429;

    // control bits that ride along a divider chain
    typedef struct packed {
        logic neg;   // sign of the final entry
        logic ovf;   // quotient does not fit, saturate
    } t_div_tag;

endpackage

`default_nettype wire

/* hw/rtl/rpj_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rpj_sqrt_cell
// One digit step of a pipelined integer square root (one root bit per cell).
// ----------------------------------------------------------------------------
`default_nettype none

module rpj_sqrt_cell #(
    parameter int VAL_W = 64,
    parameter int STEP  = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [VAL_W-1:0] i_rem,
    input  wire logic [VAL_W-1:0] i_root,
    output logic      [VAL_W-1:0] o_rem,
    output logic      [VAL_W-1:0] o_root
);

    localparam logic [VAL_W-1:0] BIT = VAL_W'(1) << (VAL_W - 2 - 2 * STEP);

    logic [VAL_W:0]   trial;
    logic             fits;
    logic [VAL_W-1:0] n_rem;
    logic [VAL_W-1:0] n_root;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_root;

    assign trial = {1'b0, i_root} + {1'b0, BIT};
    assign fits  = {1'b0, i_rem} >= trial;

    always_comb begin
        if (fits) begin
            n_rem  = i_rem - trial[VAL_W-1:0];
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

`default_nettype wire

/* hw/rtl/rpj_sqrt.sv */
// ----------------------------------------------------------------------------
// rpj_sqrt
// Pipelined floor square root: a row of VAL_W/2 digit cells.
// ----------------------------------------------------------------------------
`default_nettype none

module rpj_sqrt #(
    parameter int VAL_W = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [VAL_W-1:0] i_val,
    output logic      [VAL_W-1:0] o_root,
    output logic      [VAL_W-1:0] o_rem
);

    localparam int STEPS = VAL_W / 2;

    logic [VAL_W-1:0] rem_w  [STEPS+1];
    logic [VAL_W-1:0] root_w [STEPS+1];

    assign rem_w[0]  = i_val;
    assign root_w[0] = '0;

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        rpj_sqrt_cell #(
            .VAL_W (VAL_W),
            .STEP  (k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_rem  (rem_w[k]),
            .i_root (root_w[k]),
            .o_rem  (rem_w[k+1]),
            .o_root (root_w[k+1])
        );
    end

    assign o_root = root_w[STEPS];
    assign o_rem  = rem_w[STEPS];

endmodule

`default_nettype wire

/* hw/rtl/rpj_div_cell.sv */
// ----------------------------------------------------------------------------
// rpj_div_cell
// One restoring-division step: decides a single quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rpj_div_cell #(
    parameter int REM_W = 64,
    parameter int DEN_W = 33,
    parameter int Q_W   = 32,
    parameter int SHIFT = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [REM_W-1:0]  i_rem,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [Q_W-1:0]    i_quo,
    input  wire rpj_pkg::t_div_tag i_tag,
    output logic      [REM_W-1:0]  o_rem,
    output logic      [DEN_W-1:0]  o_den,
    output logic      [Q_W-1:0]    o_quo,
    output rpj_pkg::t_div_tag      o_tag
);

    logic [REM_W:0]     diff;
    logic [Q_W-1:0]     n_quo;
    logic [REM_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [Q_W-1:0]     r_quo;
    rpj_pkg::t_div_tag  r_tag;

    assign diff = {1'b0, i_rem} - {1'b0, REM_W'(i_den) << SHIFT};

    always_comb begin
        n_quo        = i_quo;
        n_quo[SHIFT] = ~diff[REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= diff[REM_W] ? i_rem : diff[REM_W-1:0];
            r_den <= i_den;
            r_quo <= n_quo;
            r_tag <= i_tag;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;
    assign o_tag = r_tag;

endmodule

`default_nettype wire

/* hw/rtl/rpj_divider.sv */
// ----------------------------------------------------------------------------
// rpj_divider
// Pipelined rounded magnitude division with signed saturating result.
// Quotient = floor((2n + d) / 2d), i.e. nearest with ties away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rpj_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int Q_W   = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic             i_neg,
    output logic      [Q_W-1:0]   o_res
);

    localparam int SUM_W = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 2;
    localparam int D2_W  = DEN_W + 1;
    localparam int REM_W = (SUM_W > D2_W + Q_W) ? SUM_W : D2_W + Q_W;
    localparam logic [Q_W-1:0] HALF = Q_W'(1) << (Q_W - 1);

    // prep stage
    logic [REM_W-1:0]  r_p_num;
    logic [D2_W-1:0]   r_p_den;
    logic              r_p_neg;
    // range check stage
    logic [REM_W-1:0]  r_o_num;
    logic [D2_W-1:0]   r_o_den;
    rpj_pkg::t_div_tag r_o_tag;
    // pack stage
    logic [Q_W-1:0]    r_res;

    logic [REM_W-1:0]  rem_w [Q_W+1];
    logic [D2_W-1:0]   den_w [Q_W+1];
    logic [Q_W-1:0]    quo_w [Q_W+1];
    rpj_pkg::t_div_tag tag_w [Q_W+1];

    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_num     <= REM_W'({i_num, 1'b0}) + REM_W'(i_den);
            r_p_den     <= {i_den, 1'b0};
            r_p_neg     <= i_neg;
            r_o_num     <= r_p_num;
            r_o_den     <= r_p_den;
            r_o_tag.neg <= r_p_neg;
            r_o_tag.ovf <= r_p_num >= (REM_W'(r_p_den) << Q_W);
        end
    end

    assign rem_w[0] = r_o_num;
    assign den_w[0] = r_o_den;
    assign quo_w[0] = '0;
    assign tag_w[0] = r_o_tag;

    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        rpj_div_cell #(
            .REM_W (REM_W),
            .DEN_W (D2_W),
            .Q_W   (Q_W),
            .SHIFT (Q_W - 1 - k)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (rem_w[k]),
            .i_den (den_w[k]),
            .i_quo (quo_w[k]),
            .i_tag (tag_w[k]),
            .o_rem (rem_w[k+1]),
            .o_den (den_w[k+1]),
            .o_quo (quo_w[k+1]),
            .o_tag (tag_w[k+1])
        );
    end

    // saturate to the signed range, then apply the sign
    always_comb begin
        lim = tag_w[Q_W].neg ? HALF : HALF - Q_W'(1);
        mag = (tag_w[Q_W].ovf || (quo_w[Q_W] > lim)) ? lim : quo_w[Q_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= tag_w[Q_W].neg ? (~mag + Q_W'(1)) : mag;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

/* hw/rtl/radar_polar_jacobian.sv */
// ----------------------------------------------------------------------------
// radar_polar_jacobian
// EKF radar measurement Jacobian (range, bearing, range rate), fixed point.
//
// Input stream: one state vector per transfer, tdata = pos_x, pos_y, vel_x,
// vel_y (signed Q(W-F).F each). Output stream: one transfer per input with
// range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy, each
// rounded to nearest (ties away from zero) and saturated to W bits.
// Config: i_cfg_wr_en/i_cfg_wr_data load the px^2+py^2 floor (Q.2F);
// write it only while no transfer is in flight.
// Throughput: one transfer per cycle while the skid register is empty. Path
// from the input transfer to o_m_axis_tvalid: stages A, B, C, the square-root
// cell row (one root bit per cell), stages R, E, G, the divider rows (prep,
// range check, one quotient bit per cell, pack) and the output register.
// Reset: pipeline and output empty, floor back to 429.
// Stall: a skid register catches one result when the sink holds tready low;
// then the pipeline freezes and o_s_axis_tready drops until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module radar_polar_jacobian #(
    parameter int DATA_WIDTH = rpj_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rpj_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // pos_x, pos_y, vel_x, vel_y from bit 0 up
    input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy from bit 0 up
    output logic      [((6*DATA_WIDTH+7)/8)*8-1:0]      o_m_axis_tdata,
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [rpj_pkg::CFG_W-1:0]              i_cfg_wr_data
);

    localparam int W     = DATA_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int C1_W  = 2 * W;
    localparam int C3_W  = 3 * W;
    localparam int OUT_W = ((6 * W + 7) / 8) * 8;
    localparam int L     = 2 * W + 9;

    typedef struct packed {
        logic [W-1:0]    px;
        logic [W-1:0]    py;
        logic            npx;
        logic            npy;
        logic [C1_W-1:0] c1;
        logic [C1_W-1:0] cr;
    } t_sq_pay;

    logic                      en;
    logic [L-1:0]              r_vld;
    logic [rpj_pkg::CFG_W-1:0] r_min_rsq;

    // stage A: magnitudes and signs
    logic [W-1:0] r_a_px, r_a_py, r_a_vx, r_a_vy;
    logic         r_a_npx, r_a_npy, r_a_nvx, r_a_nvy;
    // stage B: products
    logic [C1_W-1:0] r_b_pxx, r_b_pyy, r_b_a, r_b_b;
    logic [W-1:0]    r_b_px, r_b_py;
    logic            r_b_npx, r_b_npy, r_b_na, r_b_nb;
    // stage C
    t_sq_pay r_c_pay;
    t_sq_pay r_sq_pay [W];
    logic [C1_W-1:0] sq_root, sq_rem;
    // stage R
    logic [W-1:0]    r_r_c2, r_r_px, r_r_py;
    logic [C1_W-1:0] r_r_c1, r_r_crm;
    logic            r_r_npx, r_r_npy, r_r_ncr;
    // stage E
    logic [C1_W-1:0] r_e_c3_lo, r_e_c3_hi, r_e_ny_lo, r_e_ny_hi, r_e_nx_lo, r_e_nx_hi;
    logic [W-1:0]    r_e_c2, r_e_px, r_e_py;
    logic [C1_W-1:0] r_e_c1;
    logic            r_e_npx, r_e_npy, r_e_ncr;
    // stage G
    logic [C3_W-1:0] r_g_c3, r_g_ny, r_g_nx;
    logic [W-1:0]    r_g_c2, r_g_px, r_g_py;
    logic [C1_W-1:0] r_g_c1;
    logic            r_g_npx, r_g_npy, r_g_ncr;

    logic [W-1:0] res [6];

    logic [rpj_pkg::CFG_W-1:0] floor_v;
    logic [C1_W-1:0]           c1_sum, c1_floor, cr_x, cr_y;
    logic [OUT_W-1:0]          pipe_data;
    logic [OUT_W-1:0]          r_o_data, r_skid_data;
    logic                      r_o_v, r_skid_v;

    // pipeline moves unless the skid register is occupied
    assign en              = ~r_skid_v;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rsq <= rpj_pkg::MIN_RSQ_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_rsq <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_s_axis_tvalid};
        end
    end

    // stage A
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_npx <= i_s_axis_tdata[W-1];
            r_a_npy <= i_s_axis_tdata[2*W-1];
            r_a_nvx <= i_s_axis_tdata[3*W-1];
            r_a_nvy <= i_s_axis_tdata[4*W-1];
            r_a_px  <= i_s_axis_tdata[W-1] ? ~i_s_axis_tdata[0 +: W] + W'(1)
                                           : i_s_axis_tdata[0 +: W];
            r_a_py  <= i_s_axis_tdata[2*W-1] ? ~i_s_axis_tdata[W +: W] + W'(1)
                                             : i_s_axis_tdata[W +: W];
            r_a_vx  <= i_s_axis_tdata[3*W-1] ? ~i_s_axis_tdata[2*W +: W] + W'(1)
                                             : i_s_axis_tdata[2*W +: W];
            r_a_vy  <= i_s_axis_tdata[4*W-1] ? ~i_s_axis_tdata[3*W +: W] + W'(1)
                                             : i_s_axis_tdata[3*W +: W];
        end
    end

    // stage B
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_pxx <= C1_W'(r_a_px) * C1_W'(r_a_px);
            r_b_pyy <= C1_W'(r_a_py) * C1_W'(r_a_py);
            r_b_a   <= C1_W'(r_a_vx) * C1_W'(r_a_py);
            r_b_b   <= C1_W'(r_a_vy) * C1_W'(r_a_px);
            r_b_na  <= r_a_nvx ^ r_a_npy;
            r_b_nb  <= r_a_nvy ^ r_a_npx;
            r_b_px  <= r_a_px;
            r_b_py  <= r_a_py;
            r_b_npx <= r_a_npx;
            r_b_npy <= r_a_npy;
        end
    end

    // stage C: floored c1, cross = (+/-a) - (+/-b) folded into one add
    always_comb begin
        floor_v  = (r_min_rsq == '0) ? rpj_pkg::CFG_W'(1) : r_min_rsq;
        c1_sum   = r_b_pxx + r_b_pyy;
        c1_floor = C1_W'(floor_v);
        cr_x     = r_b_na ? ~r_b_a : r_b_a;
        cr_y     = r_b_nb ? r_b_b : ~r_b_b;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_pay.px  <= r_b_px;
            r_c_pay.py  <= r_b_py;
            r_c_pay.npx <= r_b_npx;
            r_c_pay.npy <= r_b_npy;
            r_c_pay.c1  <= (c1_sum < c1_floor) ? c1_floor : c1_sum;
            r_c_pay.cr  <= cr_x + cr_y + C1_W'(r_b_na) + C1_W'(!r_b_nb);
        end
    end

    rpj_sqrt #(
        .VAL_W (C1_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_c_pay.c1),
        .o_root (sq_root),
        .o_rem  (sq_rem)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_pay[0] <= r_c_pay;
            for (int k = 1; k < W; k++) begin
                r_sq_pay[k] <= r_sq_pay[k-1];
            end
        end
    end

    // stage R: round the root, cross magnitude
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_c2  <= W'(sq_root + C1_W'(sq_rem > sq_root));
            r_r_c1  <= r_sq_pay[W-1].c1;
            r_r_ncr <= r_sq_pay[W-1].cr[C1_W-1];
            r_r_crm <= r_sq_pay[W-1].cr[C1_W-1] ? ~r_sq_pay[W-1].cr + C1_W'(1)
                                                : r_sq_pay[W-1].cr;
            r_r_px  <= r_sq_pay[W-1].px;
            r_r_py  <= r_sq_pay[W-1].py;
            r_r_npx <= r_sq_pay[W-1].npx;
            r_r_npy <= r_sq_pay[W-1].npy;
        end
    end

    // stage E: partial products of c1*c2, py*crm, px*crm
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_c3_lo <= C1_W'(r_r_c1[W-1:0]) * C1_W'(r_r_c2);
            r_e_c3_hi <= C1_W'(r_r_c1[C1_W-1:W]) * C1_W'(r_r_c2);
            r_e_ny_lo <= C1_W'(r_r_py) * C1_W'(r_r_crm[W-1:0]);
            r_e_ny_hi <= C1_W'(r_r_py) * C1_W'(r_r_crm[C1_W-1:W]);
            r_e_nx_lo <= C1_W'(r_r_px) * C1_W'(r_r_crm[W-1:0]);
            r_e_nx_hi <= C1_W'(r_r_px) * C1_W'(r_r_crm[C1_W-1:W]);
            r_e_c2    <= r_r_c2;
            r_e_c1    <= r_r_c1;
            r_e_px    <= r_r_px;
            r_e_py    <= r_r_py;
            r_e_npx   <= r_r_npx;
            r_e_npy   <= r_r_npy;
            r_e_ncr   <= r_r_ncr;
        end
    end

    // stage G: combine partials
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_c3  <= C3_W'(r_e_c3_lo) + (C3_W'(r_e_c3_hi) << W);
            r_g_ny  <= C3_W'(r_e_ny_lo) + (C3_W'(r_e_ny_hi) << W);
            r_g_nx  <= C3_W'(r_e_nx_lo) + (C3_W'(r_e_nx_hi) << W);
            r_g_c2  <= r_e_c2;
            r_g_c1  <= r_e_c1;
            r_g_px  <= r_e_px;
            r_g_py  <= r_e_py;
            r_g_npx <= r_e_npx;
            r_g_npy <= r_e_npy;
            r_g_ncr <= r_e_ncr;
        end
    end

    rpj_divider #(.NUM_W (W + F), .DEN_W (W), .Q_W (W)) u_div_rdx (
        .i_clk (i_clk), .i_en (en),
        .i_num ({r_g_px, {F{1'b0}}}), .i_den (r_g_c2), .i_neg (r_g_npx),
        .o_res (res[0])
    );

    rpj_divider #(.NUM_W (W + F), .DEN_W (W), .Q_W (W)) u_div_rdy (
        .i_clk (i_clk), .i_en (en),
        .i_num ({r_g_py, {F{1'b0}}}), .i_den (r_g_c2), .i_neg (r_g_npy),
        .o_res (res[1])
    );

    rpj_divider #(.NUM_W (W + 2 * F), .DEN_W (C1_W), .Q_W (W)) u_div_bdx (
        .i_clk (i_clk), .i_en (en),
        .i_num ({r_g_py, {(2*F){1'b0}}}), .i_den (r_g_c1), .i_neg (~r_g_npy),
        .o_res (res[2])
    );

    rpj_divider #(.NUM_W (W + 2 * F), .DEN_W (C1_W), .Q_W (W)) u_div_bdy (
        .i_clk (i_clk), .i_en (en),
        .i_num ({r_g_px, {(2*F){1'b0}}}), .i_den (r_g_c1), .i_neg (r_g_npx),
        .o_res (res[3])
    );

    rpj_divider #(.NUM_W (C3_W + F), .DEN_W (C3_W), .Q_W (W)) u_div_vdx (
        .i_clk (i_clk), .i_en (en),
        .i_num ({r_g_ny, {F{1'b0}}}), .i_den (r_g_c3), .i_neg (r_g_npy ^ r_g_ncr),
        .o_res (res[4])
    );

    rpj_divider #(.NUM_W (C3_W + F), .DEN_W (C3_W), .Q_W (W)) u_div_vdy (
        .i_clk (i_clk), .i_en (en),
        .i_num ({r_g_nx, {F{1'b0}}}), .i_den (r_g_c3), .i_neg (~(r_g_npx ^ r_g_ncr)),
        .o_res (res[5])
    );

    assign pipe_data = OUT_W'({res[5], res[4], res[3], res[2], res[1], res[0]});

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v    <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_o_v || i_m_axis_tready) begin
            if (r_skid_v) begin
                r_o_v    <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_o_v    <= r_vld[L-1];
            end
        end else if (r_vld[L-1] && en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_v || i_m_axis_tready) begin
            r_o_data <= r_skid_v ? r_skid_data : pipe_data;
        end else if (r_vld[L-1] && en) begin
            r_skid_data <= pipe_data;
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = r_o_data;

endmodule

`default_nettype wire

/* bench/rpj_checker.sv */
// ----------------------------------------------------------------------------
// rpj_checker
// Watches both streams of the Jacobian block, computes each expected entry
// set from the accepted state vector and compares it with the output stream.
// ----------------------------------------------------------------------------
module rpj_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [127:0] i_s_tdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [191:0] i_m_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data,
    output int           o_errors,
    output int           o_pending,
    output int           o_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]  rsq_floor;
    logic [191:0] jac_q[$];

    // round to nearest, ties away, on magnitudes
    function automatic logic [127:0] div_round(logic [127:0] n, logic [127:0] d);
        return ((n << 1) + d) / (d << 1);
    endfunction

    function automatic logic [31:0] sat_entry(logic neg, logic [127:0] mag);
        logic [127:0] lim;
        logic [127:0] m;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        m = (mag > lim) ? lim : mag;
        return neg ? 32'(-m) : 32'(m);
    endfunction

    function automatic logic [63:0] root_round(logic [63:0] v);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= v) r |= 64'd1 << b;
        end
        if (v - r * r > r) r++;
        return r;
    endfunction

    function automatic logic [191:0] jacobian(logic [127:0] sv, logic [31:0] fl);
        logic [31:0]  f[4];
        logic         ng[4];
        logic [63:0]  mg[4];
        logic [63:0]  c1, c2, a, b, cr, crm;
        logic [127:0] c3;
        logic         ncr;
        logic [191:0] o;
        for (int i = 0; i < 4; i++) begin
            f[i]  = sv[32*i +: 32];
            ng[i] = f[i][31];
            mg[i] = ng[i] ? 64'(-f[i]) & 64'hffff_ffff : 64'(f[i]);
        end
        c1 = mg[0] * mg[0] + mg[1] * mg[1];
        if (c1 < ((fl == 0) ? 64'd1 : 64'(fl))) c1 = (fl == 0) ? 64'd1 : 64'(fl);
        c2 = root_round(c1);
        c3 = 128'(c1) * 128'(c2);
        a = mg[2] * mg[1]; if (ng[2] != ng[1]) a = -a;
        b = mg[3] * mg[0]; if (ng[3] != ng[0]) b = -b;
        cr = a - b;
        ncr = cr[63];
        crm = ncr ? -cr : cr;
        o[31:0]    = sat_entry(ng[0], div_round(128'(mg[0]) << 16, 128'(c2)));
        o[63:32]   = sat_entry(ng[1], div_round(128'(mg[1]) << 16, 128'(c2)));
        o[95:64]   = sat_entry(!ng[1], div_round(128'(mg[1]) << 32, 128'(c1)));
        o[127:96]  = sat_entry(ng[0], div_round(128'(mg[0]) << 32, 128'(c1)));
        o[159:128] = sat_entry(ng[1] != ncr,
                               div_round((128'(mg[1]) * 128'(crm)) << 16, c3));
        o[191:160] = sat_entry(ng[0] == ncr,
                               div_round((128'(mg[0]) * 128'(crm)) << 16, c3));
        return o;
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    assign o_pending = jac_q.size();

    initial begin
        o_errors = 0;
        o_seen = 0;
    end

    always @(posedge i_clk) begin
        logic [191:0] want;
        if (!i_rst_n) begin
            rsq_floor <= 32'd429;
        end else begin
            if (i_cfg_wr_en) rsq_floor <= i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) jac_q.push_back(jacobian(i_s_tdata, rsq_floor));
            if (i_m_tvalid && i_m_tready) begin
                o_seen++;
                if (jac_q.size() == 0) begin
                    report("result transfer with nothing expected");
                end else begin
                    want = jac_q.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (want[32*i +: 32] !== i_m_tdata[32*i +: 32])
                            report($sformatf("entry %0d got %h want %h", i,
                                   i_m_tdata[32*i +: 32], want[32*i +: 32]));
                end
            end
        end
    end
endmodule

/* bench/tb_radar_polar_jacobian.sv */
// ----------------------------------------------------------------------------
// tb_radar_polar_jacobian
// Drives state vectors through the radar Jacobian block under several range
// floors, with bursty input, a stalling sink and a long back-pressure hold.
// ----------------------------------------------------------------------------
module tb_radar_polar_jacobian;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 73;

    logic         i_clk;
    logic         i_rst_n;
    logic [127:0] s_tdata;     // pos_x, pos_y, vel_x, vel_y from bit 0 up
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] m_tdata;     // range_dx .. rate_dy from bit 0 up
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;
    int           errors, pending, seen, sent;
    bit           hold_sink;

    radar_polar_jacobian u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data)
    );

    rpj_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata), .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_m_tdata(m_tdata), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .o_errors(errors), .o_pending(pending), .o_seen(seen)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_radar_polar_jacobian: errors");
        $finish;
    end

    // sink stall pattern, plus a long hold on request
    initial begin
        int mode;
        m_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) m_tready <= 0;
            else begin
                mode = (seen / 64) % 3;
                if (mode == 0) m_tready <= 1;
                else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
                else m_tready <= ($urandom_range(0, 1) != 0);
            end
        end
    end

    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(signed'($urandom_range(0, 8)) - 4);
            3: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return 32'(signed'($urandom_range(0, 1 << 26)) - (1 << 25));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vec(logic [31:0] px, logic [31:0] py,
                            logic [31:0] vx, logic [31:0] vy);
        s_tdata  <= {vy, vx, py, px};
        s_tvalid <= 1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        s_tvalid <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_floor(logic [31:0] v);
        cfg_wr_en   <= 1;
        cfg_wr_data <= v;
        @(negedge i_clk);
        cfg_wr_en <= 0;
    endtask

    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n > 0; k++, n--)
                send_vec(pick_field(), pick_field(), pick_field(), pick_field());
            if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 12));
        end
    endtask

    initial begin
        logic [31:0] floors[5];
        floors = '{32'd0, 32'd1, 32'hffff_ffff, 32'd65536, $urandom};
        i_rst_n = 0; s_tvalid = 0; s_tdata = 0; cfg_wr_en = 0; cfg_wr_data = 0;
        hold_sink = 0; sent = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;

        // directed: zeros, extremes, signs, sums below the floor
        send_vec(0, 0, 0, 0);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vec(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_vec(1, 0, 32'h0001_0000, 0);
        send_vec(0, 32'hffff_ffff, 0, 32'hffff_0000);
        send_vec(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'hfffe_0000);
        send_vec(32'hffff_0000, 32'h0000_8000, 32'h7fff_ffff, 32'h0000_0001);
        send_vec(20, 5, 32'h8000_0000, 32'h7fff_ffff);
        send_vec(3, 4, 1, 2);
        send_vec(32'hffff_ffff, 32'hffff_ffff, 1, 32'hffff_ffff);
        drain();

        for (int p = 0; p < 5; p++) begin
            write_floor(floors[p]);
            if (p == 2) begin
                // hold the sink long so the pipeline backs up
                fork
                    begin
                        hold_sink = 1;
                        repeat (300) @(negedge i_clk);
                        hold_sink = 0;
                    end
                    random_phase(160);
                join
            end else random_phase(160);
            drain();
        end
        write_floor(32'd429);
        random_phase(40);
        drain();

        $display("covered %0d state vectors, %0d results, five floor settings",
                 sent, seen);
        if (errors == 0) $display("tb_radar_polar_jacobian: clean");
        else $display("tb_radar_polar_jacobian: errors");
        $finish;
    end
endmodule
